// ===== hdl/vector3_arithmetic_unit_defines.svh =====
// Assertion macros for the vector arithmetic unit.
// Used by the top level only; expects signals named clock and reset in scope.
`ifndef VECTOR3_ARITHMETIC_UNIT_DEFINES_SVH
`define VECTOR3_ARITHMETIC_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define VAU_ASSERT_IMPLY(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("vector unit assertion failed");

// Next-cycle implication, disabled during reset.
`define VAU_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("vector unit assertion failed");

`endif

// ===== hdl/vau_pkg.sv =====
// Shared types and constants of the vector arithmetic unit.
// No dependencies; compiled first.
`timescale 1ns / 1ps

package vau_pkg;

   localparam int unsigned FRAC_BITS = 16;
   localparam int unsigned WORD_W    = 32;
   localparam int unsigned OP_W      = 4;
   localparam int unsigned PROD_W    = 2 * WORD_W;
   localparam int unsigned SUM_W     = PROD_W + 2;
   localparam int unsigned RAD_W     = PROD_W;
   localparam int unsigned ROOT_W    = RAD_W / 2;
   localparam int unsigned SQ_STEPS  = ROOT_W;
   localparam int unsigned SQ_REM_W  = ROOT_W + 2;
   localparam int unsigned NUM_W     = WORD_W + FRAC_BITS;
   localparam int unsigned DEN_W     = WORD_W;

   typedef logic signed [WORD_W-1:0] word_type;

   localparam word_type WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
   localparam word_type WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

   typedef enum logic [OP_W-1:0] {
      OP_ADD   = 4'd0,
      OP_SUB   = 4'd1,
      OP_SCALE = 4'd2,
      OP_DIV   = 4'd3,
      OP_CROSS = 4'd4,
      OP_DOT   = 4'd5,
      OP_MAGSQ = 4'd6,
      OP_MAG   = 4'd7,
      OP_NORM  = 4'd8
   } op_type;

   // Per-request side data that rides along the root and divider stages.
   typedef struct packed {
      op_type          op;
      logic            use_quot;
      logic [2:0]      neg;
      word_type [2:0]  r;
      word_type        sc;
      logic            sat;
      logic            dz;
   } side_type;

endpackage

// ===== hdl/vau_req_if.sv =====
// Request channel of the vector arithmetic unit: valid/ready plus operands.
// Depends on vau_pkg.
`timescale 1ns / 1ps

interface vau_req_if;
   import vau_pkg::*;

   logic             valid;
   logic             ready;
   logic [OP_W-1:0]  operation;
   word_type         a_x;
   word_type         a_y;
   word_type         a_z;
   word_type         b_x;
   word_type         b_y;
   word_type         b_z;
   word_type         factor;

   modport source (output valid, operation, a_x, a_y, a_z, b_x, b_y, b_z, factor,
                   input ready);
   modport sink   (input valid, operation, a_x, a_y, a_z, b_x, b_y, b_z, factor,
                   output ready);
endinterface

// ===== hdl/vau_rsp_if.sv =====
// Response channel of the vector arithmetic unit: valid/ready plus results.
// Depends on vau_pkg.
`timescale 1ns / 1ps

interface vau_rsp_if;
   import vau_pkg::*;

   logic      valid;
   logic      ready;
   word_type  r_x;
   word_type  r_y;
   word_type  r_z;
   word_type  scalar_result;
   logic      saturated;
   logic      divide_by_zero;

   modport source (output valid, r_x, r_y, r_z, scalar_result, saturated, divide_by_zero,
                   input ready);
   modport sink   (input valid, r_x, r_y, r_z, scalar_result, saturated, divide_by_zero,
                   output ready);
endinterface

// ===== hdl/vau_div_lane.sv =====
// One lane of the pipelined restoring divider, one quotient bit per stage.
// Depends on vau_pkg.
`timescale 1ns / 1ps

module vau_div_lane (
   input  logic                        clock,
   input  logic                        en,
   input  logic [vau_pkg::NUM_W-1:0]   dividend,
   input  logic [vau_pkg::DEN_W-1:0]   divisor,
   output logic [vau_pkg::NUM_W-1:0]   quotient
);
   import vau_pkg::*;

   logic [NUM_W-1:0] num_ff [NUM_W];
   logic [NUM_W-1:0] num_in [NUM_W];
   logic [DEN_W-1:0] rem_ff [NUM_W];
   logic [DEN_W-1:0] rem_in [NUM_W];
   logic [DEN_W-1:0] den_ff [NUM_W];
   logic [NUM_W-1:0] num_src [NUM_W];
   logic [DEN_W-1:0] rem_src [NUM_W];
   logic [DEN_W-1:0] den_src [NUM_W];

   genvar k;
   generate
      for (k = 0; k < NUM_W; k++) begin : g_stage
         logic [DEN_W:0] shifted;
         logic [DEN_W:0] diff;
         logic           ge;

         if (k == 0) begin : g_first
            assign num_src[k] = dividend;
            assign rem_src[k] = '0;
            assign den_src[k] = divisor;
         end else begin : g_next
            assign num_src[k] = num_ff[k-1];
            assign rem_src[k] = rem_ff[k-1];
            assign den_src[k] = den_ff[k-1];
         end

         // shift in the next dividend bit, subtract when it fits
         assign shifted   = {rem_src[k], num_src[k][NUM_W-1]};
         assign diff      = shifted - {1'b0, den_src[k]};
         assign ge        = (shifted >= {1'b0, den_src[k]});
         assign rem_in[k] = ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
         assign num_in[k] = {num_src[k][NUM_W-2:0], ge};

         always_ff @(posedge clock) begin
            if (en) begin
               num_ff[k] <= num_in[k];
               rem_ff[k] <= rem_in[k];
               den_ff[k] <= den_src[k];
            end
         end
      end
   endgenerate

   assign quotient = num_ff[NUM_W-1];

endmodule

// ===== hdl/vector3_arithmetic_unit.sv =====
// Vector arithmetic unit: signed fixed point 3-D vector ops, fully pipelined.
// Throughput: one request per clock while the output is not held; one enable moves the pipe.
// Depth: 4 + 32 + 1 + (32 + FRAC_BITS) + 1 = 86 register stages at FRAC_BITS = 16, set by
//   the one-bit-per-stage square root and the one-bit-per-stage divider.
// Reset: synchronous, active high; clears all stage valid bits, payload is not reset.
`timescale 1ns / 1ps

`include "vector3_arithmetic_unit_defines.svh"

module vector3_arithmetic_unit (
   input  logic       clock,
   input  logic       reset,
   vau_req_if.sink    req_bus,
   vau_rsp_if.source  rsp_bus
);
   import vau_pkg::*;

   localparam int unsigned QW = SUM_W - FRAC_BITS;
   localparam logic [SUM_W-1:0] HALF = SUM_W'(1) << (FRAC_BITS - 1);
   localparam logic [NUM_W-1:0] NEG_LIM = NUM_W'(1) << (WORD_W - 1);

   // Clamp a wide two's complement value to one word; top bit of result is the clamp flag.
   function automatic logic [WORD_W:0] sat_word(input logic [QW-1:0] q);
      logic [QW-WORD_W:0] hi;
      hi = q[QW-1:WORD_W-1];
      if ((&hi) || (~|hi))
         return {1'b0, q[WORD_W-1:0]};
      else
         return {1'b1, (q[QW-1] ? WORD_MIN : WORD_MAX)};
   endfunction

   // Round to nearest, ties up: add half an LSB, drop the fraction, clamp.
   function automatic logic [WORD_W:0] round_sat(input logic [SUM_W-1:0] v);
      logic [SUM_W-1:0] t;
      t = v + HALF;
      return sat_word(t[SUM_W-1:FRAC_BITS]);
   endfunction

   function automatic logic [SUM_W-1:0] ext_prod(input logic [PROD_W-1:0] p);
      return {{(SUM_W-PROD_W){p[PROD_W-1]}}, p};
   endfunction

   function automatic logic [WORD_W-1:0] abs_word(input word_type v);
      return v[WORD_W-1] ? (WORD_W'(0) - v) : v;
   endfunction

   // Whole pipe moves together; hold everything while the output waits.
   logic en;
   logic out_vld_ff;
   assign en            = !out_vld_ff || rsp_bus.ready;
   assign req_bus.ready = en;

   // ---------------------------------------------------------------- stage 1: capture
   logic      s1_vld_ff;
   op_type    s1_op_ff;
   word_type  s1_a_ff [3];
   word_type  s1_b_ff [3];
   word_type  s1_f_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (en) begin
         s1_vld_ff <= req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_op_ff   <= op_type'(req_bus.operation);
         s1_a_ff[0] <= req_bus.a_x;
         s1_a_ff[1] <= req_bus.a_y;
         s1_a_ff[2] <= req_bus.a_z;
         s1_b_ff[0] <= req_bus.b_x;
         s1_b_ff[1] <= req_bus.b_y;
         s1_b_ff[2] <= req_bus.b_z;
         s1_f_ff    <= req_bus.factor;
      end
   end

   // ---------------------------------------------------------------- stage 2: products
   // Six signed multipliers; operands steered per operation.
   word_type                  mx [6];
   word_type                  my [6];
   logic signed [PROD_W-1:0]  prod_in [6];
   logic [WORD_W:0]           as_in [3];

   always_comb begin
      for (int i = 0; i < 6; i++) begin
         mx[i] = '0;
         my[i] = '0;
      end
      unique case (s1_op_ff)
         OP_SCALE: begin
            for (int i = 0; i < 3; i++) begin
               mx[i] = s1_a_ff[i];
               my[i] = s1_f_ff;
            end
         end
         OP_CROSS: begin
            mx[0] = s1_a_ff[1]; my[0] = s1_b_ff[2];
            mx[1] = s1_a_ff[2]; my[1] = s1_b_ff[1];
            mx[2] = s1_a_ff[2]; my[2] = s1_b_ff[0];
            mx[3] = s1_a_ff[0]; my[3] = s1_b_ff[2];
            mx[4] = s1_a_ff[0]; my[4] = s1_b_ff[1];
            mx[5] = s1_a_ff[1]; my[5] = s1_b_ff[0];
         end
         OP_DOT: begin
            for (int i = 0; i < 3; i++) begin
               mx[i] = s1_a_ff[i];
               my[i] = s1_b_ff[i];
            end
         end
         OP_MAGSQ, OP_MAG, OP_NORM: begin
            for (int i = 0; i < 3; i++) begin
               mx[i] = s1_a_ff[i];
               my[i] = s1_a_ff[i];
            end
         end
         default: begin
         end
      endcase
      for (int i = 0; i < 6; i++) begin
         prod_in[i] = mx[i] * my[i];
      end
      for (int i = 0; i < 3; i++) begin
         if (s1_op_ff == OP_SUB)
            as_in[i] = {s1_a_ff[i][WORD_W-1], s1_a_ff[i]} - {s1_b_ff[i][WORD_W-1], s1_b_ff[i]};
         else
            as_in[i] = {s1_a_ff[i][WORD_W-1], s1_a_ff[i]} + {s1_b_ff[i][WORD_W-1], s1_b_ff[i]};
      end
   end

   logic               s2_vld_ff;
   op_type             s2_op_ff;
   word_type           s2_a_ff [3];
   word_type           s2_f_ff;
   logic [WORD_W:0]    s2_as_ff [3];
   logic [PROD_W-1:0]  s2_prod_ff [6];

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else if (en) begin
         s2_vld_ff <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_op_ff <= s1_op_ff;
         s2_a_ff  <= s1_a_ff;
         s2_f_ff  <= s1_f_ff;
         s2_as_ff <= as_in;
         for (int i = 0; i < 6; i++) begin
            s2_prod_ff[i] <= prod_in[i];
         end
      end
   end

   // ---------------------------------------------------------------- stage 3: exact sums
   logic [SUM_W-1:0] vs_in [3];
   logic [SUM_W-1:0] tot_in;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (s2_op_ff == OP_CROSS)
            vs_in[i] = ext_prod(s2_prod_ff[2*i]) - ext_prod(s2_prod_ff[2*i+1]);
         else
            vs_in[i] = ext_prod(s2_prod_ff[i]);
      end
      tot_in = ext_prod(s2_prod_ff[0]) + ext_prod(s2_prod_ff[1]) + ext_prod(s2_prod_ff[2]);
   end

   logic              s3_vld_ff;
   op_type            s3_op_ff;
   word_type          s3_a_ff [3];
   word_type          s3_f_ff;
   logic [WORD_W:0]   s3_as_ff [3];
   logic [SUM_W-1:0]  s3_vs_ff [3];
   logic [SUM_W-1:0]  s3_tot_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_vld_ff <= 1'b0;
      end else if (en) begin
         s3_vld_ff <= s2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s3_op_ff  <= s2_op_ff;
         s3_a_ff   <= s2_a_ff;
         s3_f_ff   <= s2_f_ff;
         s3_as_ff  <= s2_as_ff;
         s3_vs_ff  <= vs_in;
         s3_tot_ff <= tot_in;
      end
   end

   // ---------------------------------------------------------------- stage 4: round, clamp
   // Finish everything that needs no root or quotient. Normalise and a nonzero divide park
   // the operand vector in r; a nonzero divide parks |factor| in sc as the divisor.
   logic [WORD_W:0] rv [3];
   logic [WORD_W:0] cl [3];
   logic [WORD_W:0] rt;
   side_type        s4_side_in;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         rv[i] = round_sat(s3_vs_ff[i]);
         cl[i] = sat_word({{(QW-WORD_W-1){s3_as_ff[i][WORD_W]}}, s3_as_ff[i]});
      end
      rt = round_sat(s3_tot_ff);

      s4_side_in    = '0;
      s4_side_in.op = s3_op_ff;
      unique case (s3_op_ff)
         OP_ADD, OP_SUB: begin
            for (int i = 0; i < 3; i++) begin
               s4_side_in.r[i] = cl[i][WORD_W-1:0];
               s4_side_in.sat  = s4_side_in.sat | cl[i][WORD_W];
            end
         end
         OP_SCALE, OP_CROSS: begin
            for (int i = 0; i < 3; i++) begin
               s4_side_in.r[i] = rv[i][WORD_W-1:0];
               s4_side_in.sat  = s4_side_in.sat | rv[i][WORD_W];
            end
         end
         OP_DOT, OP_MAGSQ: begin
            s4_side_in.sc  = rt[WORD_W-1:0];
            s4_side_in.sat = rt[WORD_W];
         end
         OP_DIV: begin
            if (s3_f_ff == '0) begin
               // zero divisor: saturate by sign of the numerator
               s4_side_in.dz = 1'b1;
               for (int i = 0; i < 3; i++) begin
                  if (s3_a_ff[i][WORD_W-1])
                     s4_side_in.r[i] = WORD_MIN;
                  else if (s3_a_ff[i] != '0)
                     s4_side_in.r[i] = WORD_MAX;
               end
            end else begin
               s4_side_in.use_quot = 1'b1;
               s4_side_in.sc       = abs_word(s3_f_ff);
               for (int i = 0; i < 3; i++) begin
                  s4_side_in.r[i]   = s3_a_ff[i];
                  s4_side_in.neg[i] = s3_a_ff[i][WORD_W-1] ^ s3_f_ff[WORD_W-1];
               end
            end
         end
         OP_NORM: begin
            for (int i = 0; i < 3; i++) begin
               s4_side_in.r[i]   = s3_a_ff[i];
               s4_side_in.neg[i] = s3_a_ff[i][WORD_W-1];
            end
         end
         default: begin
         end
      endcase
   end

   logic              s4_vld_ff;
   side_type          s4_side_ff;
   logic [RAD_W-1:0]  s4_rad_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_vld_ff <= 1'b0;
      end else if (en) begin
         s4_vld_ff <= s3_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s4_side_ff <= s4_side_in;
         s4_rad_ff  <= s3_tot_ff[RAD_W-1:0];
      end
   end

   // ---------------------------------------------------------------- square root
   // One root bit per stage: bring down two radicand bits, try (root << 2) | 1.
   logic                 sq_vld_ff  [SQ_STEPS];
   side_type             sq_side_ff [SQ_STEPS];
   logic [RAD_W-1:0]     sq_rad_ff  [SQ_STEPS];
   logic [SQ_REM_W-1:0]  sq_rem_ff  [SQ_STEPS];
   logic [ROOT_W-1:0]    sq_root_ff [SQ_STEPS];
   logic [SQ_REM_W-1:0]  sq_rem_in  [SQ_STEPS];
   logic [ROOT_W-1:0]    sq_root_in [SQ_STEPS];

   genvar k;
   generate
      for (k = 0; k < SQ_STEPS; k++) begin : g_sqrt
         logic                 vld_src;
         side_type             side_src;
         logic [RAD_W-1:0]     rad_src;
         logic [SQ_REM_W-1:0]  rem_src;
         logic [ROOT_W-1:0]    root_src;
         logic [SQ_REM_W-1:0]  shifted;
         logic [SQ_REM_W-1:0]  trial;
         logic                 ge;

         if (k == 0) begin : g_first
            assign vld_src  = s4_vld_ff;
            assign side_src = s4_side_ff;
            assign rad_src  = s4_rad_ff;
            assign rem_src  = '0;
            assign root_src = '0;
         end else begin : g_next
            assign vld_src  = sq_vld_ff[k-1];
            assign side_src = sq_side_ff[k-1];
            assign rad_src  = sq_rad_ff[k-1];
            assign rem_src  = sq_rem_ff[k-1];
            assign root_src = sq_root_ff[k-1];
         end

         assign shifted       = {rem_src[SQ_REM_W-3:0], rad_src[RAD_W-1 -: 2]};
         assign trial         = {root_src, 2'b01};
         assign ge            = (shifted >= trial);
         assign sq_rem_in[k]  = ge ? (shifted - trial) : shifted;
         assign sq_root_in[k] = {root_src[ROOT_W-2:0], ge};

         always_ff @(posedge clock) begin
            if (reset) begin
               sq_vld_ff[k] <= 1'b0;
            end else if (en) begin
               sq_vld_ff[k] <= vld_src;
            end
         end

         always_ff @(posedge clock) begin
            if (en) begin
               sq_side_ff[k] <= side_src;
               sq_rad_ff[k]  <= rad_src << 2;
               sq_rem_ff[k]  <= sq_rem_in[k];
               sq_root_ff[k] <= sq_root_in[k];
            end
         end
      end
   endgenerate

   // ---------------------------------------------------------------- root rounding
   // Round the root up when the remainder exceeds it; pick the divisor.
   logic [ROOT_W-1:0]  mag;
   side_type           rs_side_in;
   logic [DEN_W-1:0]   rs_den_in;
   logic [NUM_W-1:0]   rs_num_in [3];

   always_comb begin
      mag = sq_root_ff[SQ_STEPS-1]
          + ROOT_W'(sq_rem_ff[SQ_STEPS-1] > SQ_REM_W'(sq_root_ff[SQ_STEPS-1]));
      rs_side_in = sq_side_ff[SQ_STEPS-1];
      rs_den_in  = mag;
      if (rs_side_in.op == OP_MAG) begin
         rs_side_in.sat = mag[ROOT_W-1];
         rs_side_in.sc  = mag[ROOT_W-1] ? WORD_MAX : word_type'(mag);
      end else if (rs_side_in.op == OP_NORM) begin
         rs_side_in.use_quot = (mag != '0);
      end else if (rs_side_in.op == OP_DIV) begin
         rs_den_in     = rs_side_in.sc;
         rs_side_in.sc = '0;
      end
      for (int i = 0; i < 3; i++) begin
         rs_num_in[i] = {abs_word(rs_side_in.r[i]), {FRAC_BITS{1'b0}}};
      end
   end

   logic              rs_vld_ff;
   side_type          rs_side_ff;
   logic [DEN_W-1:0]  rs_den_ff;
   logic [NUM_W-1:0]  rs_num_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         rs_vld_ff <= 1'b0;
      end else if (en) begin
         rs_vld_ff <= sq_vld_ff[SQ_STEPS-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rs_side_ff <= rs_side_in;
         rs_den_ff  <= rs_den_in;
         rs_num_ff  <= rs_num_in;
      end
   end

   // ---------------------------------------------------------------- divider
   // Three magnitude dividers; side data follows in a matching delay line.
   logic [NUM_W-1:0] quo [3];

   generate
      for (k = 0; k < 3; k++) begin : g_lane
         vau_div_lane u_lane (
            .clock    (clock),
            .en       (en),
            .dividend (rs_num_ff[k]),
            .divisor  (rs_den_ff),
            .quotient (quo[k])
         );
      end
   endgenerate

   logic      dv_vld_ff  [NUM_W];
   side_type  dv_side_ff [NUM_W];

   generate
      for (k = 0; k < NUM_W; k++) begin : g_delay
         logic      vld_src;
         side_type  side_src;

         if (k == 0) begin : g_first
            assign vld_src  = rs_vld_ff;
            assign side_src = rs_side_ff;
         end else begin : g_next
            assign vld_src  = dv_vld_ff[k-1];
            assign side_src = dv_side_ff[k-1];
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               dv_vld_ff[k] <= 1'b0;
            end else if (en) begin
               dv_vld_ff[k] <= vld_src;
            end
         end

         always_ff @(posedge clock) begin
            if (en) begin
               dv_side_ff[k] <= side_src;
            end
         end
      end
   endgenerate

   // ---------------------------------------------------------------- output
   // Apply sign and clamp to the quotients, or pass the early result.
   side_type fin;
   word_type out_r_in [3];
   logic     out_sat_in;

   always_comb begin
      fin        = dv_side_ff[NUM_W-1];
      out_sat_in = fin.sat;
      for (int i = 0; i < 3; i++) begin
         out_r_in[i] = fin.r[i];
         if (fin.use_quot) begin
            if (fin.neg[i]) begin
               if (quo[i] > NEG_LIM) begin
                  out_r_in[i] = WORD_MIN;
                  out_sat_in  = 1'b1;
               end else begin
                  out_r_in[i] = WORD_W'(0) - quo[i][WORD_W-1:0];
               end
            end else begin
               if (quo[i][NUM_W-1:WORD_W-1] != '0) begin
                  out_r_in[i] = WORD_MAX;
                  out_sat_in  = 1'b1;
               end else begin
                  out_r_in[i] = quo[i][WORD_W-1:0];
               end
            end
         end
      end
   end

   word_type  out_r_ff [3];
   word_type  out_sc_ff;
   logic      out_sat_ff;
   logic      out_dz_ff;
   op_type    out_op_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (en) begin
         out_vld_ff <= dv_vld_ff[NUM_W-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_r_ff   <= out_r_in;
         out_sc_ff  <= fin.sc;
         out_sat_ff <= out_sat_in;
         out_dz_ff  <= fin.dz;
         out_op_ff  <= fin.op;
      end
   end

   assign rsp_bus.valid          = out_vld_ff;
   assign rsp_bus.r_x            = out_r_ff[0];
   assign rsp_bus.r_y            = out_r_ff[1];
   assign rsp_bus.r_z            = out_r_ff[2];
   assign rsp_bus.scalar_result  = out_sc_ff;
   assign rsp_bus.saturated      = out_sat_ff;
   assign rsp_bus.divide_by_zero = out_dz_ff;

   // ---------------------------------------------------------------- checks
   logic [SQ_REM_W-1:0] root_x2;
   logic                out_scalar_op;
   logic                out_vec_zero;

   assign root_x2       = SQ_REM_W'(sq_root_ff[SQ_STEPS-1]) << 1;
   assign out_scalar_op = (out_op_ff == OP_DOT) || (out_op_ff == OP_MAGSQ)
                       || (out_op_ff == OP_MAG);
   assign out_vec_zero  = (out_r_ff[0] == '0) && (out_r_ff[1] == '0) && (out_r_ff[2] == '0);

   // Root remainder never exceeds twice the root.
   `VAU_ASSERT_IMPLY(a_root_rem, sq_vld_ff[SQ_STEPS-1], sq_rem_ff[SQ_STEPS-1] <= root_x2)
   // Zero divisor flag only on divides, never together with clamping.
   `VAU_ASSERT_IMPLY(a_dz_op, out_vld_ff && out_dz_ff, out_op_ff == OP_DIV && !out_sat_ff)
   // Scalar operations leave the vector at zero.
   `VAU_ASSERT_IMPLY(a_scalar_vec, out_vld_ff && out_scalar_op, out_vec_zero)
   // A stalled request in the first stage stays there.
   `VAU_ASSERT_NEXT(a_stall_hold, s1_vld_ff && !en, s1_vld_ff)

endmodule

// ===== tb/vau_tb_pkg.sv =====
// Request and result record types shared by the vector unit testbench.
// Depends on vau_pkg.
`timescale 1ns / 1ps

package vau_tb_pkg;
   import vau_pkg::*;

   typedef struct {
      logic [OP_W-1:0] operation;
      word_type        a_x, a_y, a_z, b_x, b_y, b_z, factor;
   } vec_request_type;

   typedef struct {
      word_type r_x, r_y, r_z, scalar_result;
      logic     saturated, divide_by_zero;
   } vec_result_type;

endpackage

// ===== tb/vau_tb_if.sv =====
// Testbench note: the block's channel interfaces live with the RTL (vau_req_if, vau_rsp_if).
// This file only holds a small probe interface used to pass the checker's verdict.
`timescale 1ns / 1ps

interface vau_verdict_if;
   int unsigned fail_count;
   int unsigned result_count;
   int unsigned pending;
   modport source (output fail_count, result_count, pending);
   modport sink   (input fail_count, result_count, pending);
endinterface

// ===== tb/vau_result_checker.sv =====
// Checker of the vector arithmetic unit: watches both channels, predicts results and
// compares them in order. Depends on vau_pkg, vau_tb_pkg and the channel interfaces.
`timescale 1ns / 1ps

module vau_result_checker (
   input  logic          clock,
   input  logic          reset,
   vau_req_if.sink       req_mon,
   vau_rsp_if.sink       rsp_mon,
   vau_verdict_if.source verdict
);
   import vau_pkg::*;
   import vau_tb_pkg::*;

   localparam longint LMAX = 64'sd2147483647;
   localparam longint LMIN = -64'sd2147483648;

   vec_result_type expected_results[$];
   int unsigned mismatches = 0;
   int unsigned results_seen = 0;
   bit          clamp_hit;

   assign verdict.fail_count   = mismatches;
   assign verdict.result_count = results_seen;
   assign verdict.pending      = expected_results.size();

   function automatic logic signed [127:0] fx_clamp(logic signed [127:0] v);
      if (v > LMAX) begin
         clamp_hit = 1;
         return LMAX;
      end
      if (v < LMIN) begin
         clamp_hit = 1;
         return LMIN;
      end
      return v;
   endfunction

   // exact sum of products, add half an LSB, floor
   function automatic word_type fx_round(logic signed [127:0] s);
      logic signed [127:0] t;
      t = (s + (128'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
      return word_type'(fx_clamp(t));
   endfunction

   function automatic word_type fx_quot(longint num, longint den);
      logic signed [127:0] n, d, q;
      n = num;
      d = den;
      n = n <<< FRAC_BITS;
      q = n / d;
      return word_type'(fx_clamp(q));
   endfunction

   function automatic logic [127:0] root_nearest(logic [127:0] s);
      logic [127:0] lo, hi, mid;
      lo = 0;
      hi = 128'd1 << 34;
      while (hi - lo > 1) begin
         mid = (lo + hi) >> 1;
         if (mid * mid <= s) lo = mid;
         else hi = mid;
      end
      // round up when s - lo^2 exceeds lo
      if (s - lo * lo > lo) lo = lo + 1;
      return lo;
   endfunction

   function automatic vec_result_type compute_vector_op(vec_request_type q);
      vec_result_type res;
      longint       a[3], b[3], f;
      logic signed [127:0] s;
      logic [127:0] m;
      word_type     r[3];
      int           j, k;
      res = '{default: '0};
      r = '{default: '0};
      a = '{q.a_x, q.a_y, q.a_z};
      b = '{q.b_x, q.b_y, q.b_z};
      f = q.factor;
      clamp_hit = 0;
      case (q.operation)
         OP_ADD:   for (int i = 0; i < 3; i++) r[i] = word_type'(fx_clamp(a[i] + b[i]));
         OP_SUB:   for (int i = 0; i < 3; i++) r[i] = word_type'(fx_clamp(a[i] - b[i]));
         OP_SCALE: for (int i = 0; i < 3; i++) r[i] = fx_round(128'(a[i]) * f);
         OP_DIV: begin
            if (f == 0) begin
               res.divide_by_zero = 1;
               for (int i = 0; i < 3; i++)
                  r[i] = a[i] > 0 ? WORD_MAX : (a[i] < 0 ? WORD_MIN : '0);
            end else begin
               for (int i = 0; i < 3; i++) r[i] = fx_quot(a[i], f);
            end
         end
         OP_CROSS: begin
            for (int i = 0; i < 3; i++) begin
               j = (i + 1) % 3;
               k = (i + 2) % 3;
               s = 128'(a[j]) * b[k] - 128'(a[k]) * b[j];
               r[i] = fx_round(s);
            end
         end
         OP_DOT, OP_MAGSQ: begin
            s = 0;
            for (int i = 0; i < 3; i++)
               s += 128'(a[i]) * (q.operation == OP_DOT ? b[i] : a[i]);
            res.scalar_result = fx_round(s);
         end
         OP_MAG, OP_NORM: begin
            s = 0;
            for (int i = 0; i < 3; i++) s += 128'(a[i]) * a[i];
            m = root_nearest(s);
            if (q.operation == OP_MAG) begin
               if (m > LMAX) begin
                  clamp_hit = 1;
                  res.scalar_result = WORD_MAX;
               end else begin
                  res.scalar_result = word_type'(m);
               end
            end else if (m == 0) begin
               for (int i = 0; i < 3; i++) r[i] = word_type'(a[i]);
            end else begin
               for (int i = 0; i < 3; i++) r[i] = fx_quot(a[i], longint'(m));
            end
         end
         default: ;
      endcase
      res.r_x = r[0];
      res.r_y = r[1];
      res.r_z = r[2];
      res.saturated = clamp_hit;
      return res;
   endfunction

   always @(posedge clock) begin
      vec_request_type q;
      vec_result_type  got, want;
      if (!reset && req_mon.valid && req_mon.ready) begin
         q.operation = req_mon.operation;
         q.a_x = req_mon.a_x;
         q.a_y = req_mon.a_y;
         q.a_z = req_mon.a_z;
         q.b_x = req_mon.b_x;
         q.b_y = req_mon.b_y;
         q.b_z = req_mon.b_z;
         q.factor = req_mon.factor;
         expected_results.push_back(compute_vector_op(q));
      end
      if (!reset && rsp_mon.valid && rsp_mon.ready) begin
         got.r_x = rsp_mon.r_x;
         got.r_y = rsp_mon.r_y;
         got.r_z = rsp_mon.r_z;
         got.scalar_result = rsp_mon.scalar_result;
         got.saturated = rsp_mon.saturated;
         got.divide_by_zero = rsp_mon.divide_by_zero;
         results_seen++;
         if (expected_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result at %0t", $realtime);
         end else begin
            want = expected_results.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("result %0d mismatch: exp %h %h %h %h s%b z%b got %h %h %h %h s%b z%b",
                           results_seen, want.r_x, want.r_y, want.r_z, want.scalar_result,
                           want.saturated, want.divide_by_zero, got.r_x, got.r_y, got.r_z,
                           got.scalar_result, got.saturated, got.divide_by_zero);
            end
         end
      end
   end

endmodule

// ===== tb/vector3_arithmetic_unit_tb.sv =====
// Top of the vector arithmetic unit testbench: clock, reset, request stimulus and
// result back pressure. Depends on vau_pkg, the channel interfaces and vau_result_checker.
`timescale 1ns / 1ps

module vector3_arithmetic_unit_tb;
   import vau_pkg::*;

   // pipeline depth given at the head of the block
   localparam int PIPE_DEPTH    = 86;
   localparam int RANDOM_ITEMS  = 1450;

   logic clock = 0;
   logic reset = 1;

   vau_req_if     req_bus ();
   vau_rsp_if     rsp_bus ();
   vau_verdict_if verdict ();

   vector3_arithmetic_unit dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus.sink),
      .rsp_bus (rsp_bus.source)
   );

   vau_result_checker checker_i (
      .clock   (clock),
      .reset   (reset),
      .req_mon (req_bus.sink),
      .rsp_mon (rsp_bus.sink),
      .verdict (verdict.source)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   int  requests_sent = 0;
   bit  stimulus_done = 0;
   bit  long_stall_on = 0;   // raised by the stimulus to force one long receiver hold-off

   // Pick a gap: mostly none or short, sometimes long.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(99);
      if (roll < 55) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Operand value with a bias toward edges and small magnitudes.
   function automatic word_type pick_word();
      case ($urandom_range(9))
         0: return WORD_MAX;
         1: return WORD_MIN;
         2: return '0;
         3: return word_type'($signed($urandom_range(0, 32'h3_0000)) - 32'sh1_8000);
         4, 5: return word_type'($signed($urandom_range(0, 32'h200_0000)) - 32'sh100_0000);
         default: return word_type'($urandom);
      endcase
   endfunction

   // Drive one request and hold it until it is accepted.
   task automatic send_request(logic [OP_W-1:0] op, word_type ax, word_type ay, word_type az,
                               word_type bx, word_type by, word_type bz, word_type fac);
      req_bus.valid     <= 1'b1;
      req_bus.operation <= op;
      req_bus.a_x <= ax;
      req_bus.a_y <= ay;
      req_bus.a_z <= az;
      req_bus.b_x <= bx;
      req_bus.b_y <= by;
      req_bus.b_z <= bz;
      req_bus.factor <= fac;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      requests_sent++;
   endtask

   // Drop valid for a gap of idle cycles; with zero cycles valid stays high.
   task automatic idle_gap(int cycles);
      if (cycles > 0) begin
         req_bus.valid <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   task automatic send_random(logic [OP_W-1:0] op);
      send_request(op, pick_word(), pick_word(), pick_word(), pick_word(), pick_word(),
                   pick_word(), pick_word());
   endtask

   // Receiver: random ready, plus one long hold-off while requests keep coming.
   initial begin
      int gap;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (long_stall_on) begin
            rsp_bus.ready <= 1'b0;
            repeat (4 * PIPE_DEPTH) @(posedge clock);
            long_stall_on = 0;
         end
         gap = pick_gap();
         if (gap > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   end

   initial begin
      int wait_cycles;
      logic [OP_W-1:0] op;
      req_bus.valid <= 1'b0;
      req_bus.operation <= '0;
      req_bus.a_x <= '0;
      req_bus.a_y <= '0;
      req_bus.a_z <= '0;
      req_bus.b_x <= '0;
      req_bus.b_y <= '0;
      req_bus.b_z <= '0;
      req_bus.factor <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: every operation, field extremes, zero divisor, zero-length normalise,
      // saturating sums and products, unused codes.
      send_request(OP_ADD, WORD_MAX, WORD_MIN, 32'sh1_0000, 32'sh1, -32'sh1, 32'sh2_0000,
                   '0);
      send_request(OP_SUB, WORD_MIN, WORD_MAX, '0, 32'sh1, -32'sh1, '0, '0);
      send_request(OP_SCALE, WORD_MAX, WORD_MIN, 32'sh1_8000, '0, '0, '0, WORD_MAX);
      send_request(OP_SCALE, 32'sh1, -32'sh1, 32'sh3, '0, '0, '0, 32'sh8000);
      send_request(OP_DIV, 32'sh5_0000, -32'sh3_0000, '0, '0, '0, '0, '0);
      send_request(OP_DIV, WORD_MAX, WORD_MIN, 32'sh1_0000, '0, '0, '0, 32'sh1);
      send_request(OP_DIV, 32'sh7_0000, -32'sh7_0001, 32'sh1, '0, '0, '0, -32'sh3_0000);
      send_request(OP_DIV, WORD_MIN, '0, '0, '0, '0, '0, -32'sh1_0000);
      send_request(OP_CROSS, 32'sh1_0000, '0, '0, '0, 32'sh1_0000, '0, '0);
      send_request(OP_CROSS, WORD_MAX, WORD_MIN, WORD_MAX, WORD_MIN, WORD_MAX, WORD_MIN,
                   '0);
      send_request(OP_DOT, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN, '0);
      send_request(OP_DOT, 32'sh2_0000, 32'sh3_0000, -32'sh1, 32'sh1_0000, 32'sh1_0000,
                   32'sh8000, '0);
      send_request(OP_MAGSQ, 32'sh3_0000, 32'sh4_0000, '0, '0, '0, '0, '0);
      send_request(OP_MAGSQ, WORD_MAX, WORD_MAX, WORD_MAX, '0, '0, '0, '0);
      send_request(OP_MAG, 32'sh3_0000, 32'sh4_0000, '0, '0, '0, '0, '0);
      send_request(OP_MAG, WORD_MIN, WORD_MIN, WORD_MIN, '0, '0, '0, '0);
      send_request(OP_MAG, '0, '0, 32'sh2, '0, '0, '0, '0);
      send_request(OP_NORM, '0, '0, '0, 32'sh5, '0, '0, '0);
      send_request(OP_NORM, 32'sh3_0000, -32'sh4_0000, '0, '0, '0, '0, '0);
      send_request(OP_NORM, WORD_MIN, '0, '0, '0, '0, '0, '0);
      send_request(OP_NORM, '0, 32'sh1, '0, '0, '0, '0, '0);
      send_request(4'd9, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX,
                   WORD_MAX);
      send_request(4'd15, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN,
                   WORD_MIN);
      idle_gap(1);

      // Random: mostly valid operations, a few unused codes.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         // one long receiver stall with the sender pushing on, to fill the pipe
         if (n == 300) long_stall_on = 1;
         // once, hold the sender until every expected result has drained
         if (n == 700) begin
            req_bus.valid <= 1'b0;
            wait_cycles = 0;
            while (verdict.pending != 0 && wait_cycles < 20000) begin
               @(posedge clock);
               wait_cycles++;
            end
         end
         op = ($urandom_range(19) == 0) ? 4'($urandom_range(9, 15))
                                        : 4'($urandom_range(0, 8));
         send_random(op);
         if (n >= 300 && n < 500) idle_gap(0);
         else idle_gap(pick_gap());
      end
      req_bus.valid <= 1'b0;
      stimulus_done = 1;

      wait_cycles = 0;
      while (verdict.pending != 0 && wait_cycles < 50000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (2 * PIPE_DEPTH) @(posedge clock);

      $display("ran %0d requests over all nine operations plus unused codes; %0d results checked",
               requests_sent, verdict.result_count);
      if (verdict.fail_count == 0 && verdict.pending == 0)
         $display("vector3_arithmetic_unit verification clean");
      else
         $display("vector3_arithmetic_unit verification failed");
      $finish;
   end

   // Watchdog: far beyond the slowest correct run.
   initial begin
      #2_000_000;
      $display("vector3_arithmetic_unit verification failed");
      $finish;
   end

endmodule
